// ----- hdl/hrss_pkg.sv -----
// Shared constants and the result record for the RMS histogram similarity block.
// Used by hrss_front, hrss_back and histogram_rms_similarity_score; depends on nothing.
package hrss_pkg;

	localparam int BIN_W       = 8;
	localparam int SQ_W        = 16;
	localparam int MEAN_W      = 16;
	localparam int ROOT_W      = 16;
	localparam int RAD_W       = 32;
	localparam int SCORE_W     = 15;
	localparam int PROD_W      = 23;   // (255 * 256) * 100 fits in 23 bits
	localparam int RECIP_W     = 24;

	localparam logic [ROOT_W-1:0]   ROOT_MAX     = 16'd65280;  // 255.0 in Q8
	localparam logic [6:0]          SCORE_SCALE  = 7'd100;
	// Divide by 255 as a multiply by ceil(2^31 / 255) and a shift by 31; exact
	// for every dividend below 2^23.
	localparam logic [RECIP_W-1:0]  DIV255_RECIP = 24'd8421505;
	localparam int                  DIV255_SHIFT = 31;
	localparam logic [SCORE_W-1:0]  THRESH_RESET = 15'd17920;  // 70.0 in Q8

	typedef struct packed {
		logic [SCORE_W-1:0] score_q8;
		logic               is_match;
		logic [MEAN_W-1:0]  mean_square;
		logic               too_many_bins;
	} result_t;

endpackage

// ----- hdl/hrss_front.sv -----
// Front end: squares bin differences and accumulates them per histogram pair.
// Emits one job record per pair into the job queue. Uses hrss_pkg.
module hrss_front #(
	parameter int MAX_BINS = 256,
	parameter int SUM_W    = 24,
	parameter int CNT_W    = 9,
	parameter int QDEPTH   = 2,
	parameter int QCNT_W   = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [hrss_pkg::BIN_W-1:0]    bin_a,
	input  logic [hrss_pkg::BIN_W-1:0]    bin_b,
	input  logic                          last,
	input  logic [QCNT_W-1:0]             q_count,
	output logic                          job_push,
	output logic [SUM_W+CNT_W:0]          job_data
);

	logic                       valid_s1;
	logic                       last_s1;
	logic [hrss_pkg::SQ_W-1:0]  sq_s1;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       ovf_q;

	logic                       accept;
	logic [hrss_pkg::BIN_W-1:0] diff;
	logic                       in_range;
	logic [SUM_W-1:0]           sum_nx;
	logic [CNT_W-1:0]           cnt_nx;
	logic                       ovf_nx;

	// Hold off while a last item in flight could find the queue full.
	assign full = (q_count == QCNT_W'(QDEPTH)) ||
		((q_count == QCNT_W'(QDEPTH - 1)) && valid_s1 && last_s1);
	assign accept = push && !full;
	assign diff = (bin_a >= bin_b) ? (bin_a - bin_b) : (bin_b - bin_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
			sq_s1   <= hrss_pkg::SQ_W'(diff) * hrss_pkg::SQ_W'(diff);
		end
	end

	assign in_range = cnt_q < CNT_W'(MAX_BINS);
	assign sum_nx   = in_range ? (sum_q + SUM_W'(sq_s1)) : sum_q;
	assign cnt_nx   = in_range ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign ovf_nx   = ovf_q || !in_range;

	assign job_push = valid_s1 && last_s1;
	assign job_data = {ovf_nx, cnt_nx, sum_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

endmodule

// ----- hdl/hrss_job_fifo.sv -----
// Short register queue of job records between front and back end.
// Self-contained; no package use.
module hrss_job_fifo #(
	parameter int WIDTH  = 34,
	parameter int DEPTH  = 2,
	parameter int CNT_W  = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty,
	output logic [CNT_W-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/hrss_back.sv -----
// Back end: sequencer with a restoring divider for the mean, a digit-by-digit
// square root and a reciprocal multiply for the score; holds the result. Uses hrss_pkg.
module hrss_back #(
	parameter int SUM_W  = 24,
	parameter int CNT_W  = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  logic [SUM_W+CNT_W:0]            job_data,
	output logic                            job_pop,
	input  logic [hrss_pkg::SCORE_W-1:0]    threshold,
	input  logic                            pop,
	output logic                            empty,
	output hrss_pkg::result_t               result
);

	localparam int DEND_W  = (SUM_W > hrss_pkg::PROD_W) ? SUM_W : hrss_pkg::PROD_W;
	localparam int DSOR_W  = CNT_W;
	localparam int IT_W    = $clog2(DEND_W);
	localparam int SREM_W  = hrss_pkg::ROOT_W + 2;
	localparam int SPROD_W = hrss_pkg::PROD_W + hrss_pkg::RECIP_W;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DIV_MEAN  = 3'd1;
	localparam logic [2:0] ST_SQRT      = 3'd2;
	localparam logic [2:0] ST_MUL       = 3'd3;
	localparam logic [2:0] ST_OUT       = 3'd4;

	logic [2:0]                       state_q;
	logic [IT_W-1:0]                  it_q;
	logic [DSOR_W-1:0]                rem_q;
	logic [DEND_W-1:0]                quo_q;
	logic [DSOR_W-1:0]                dsor_q;
	logic                             zero_cnt_q;
	logic                             ovf_q;
	logic [hrss_pkg::MEAN_W-1:0]      mean_q;
	logic [hrss_pkg::RAD_W-1:0]       rad_q;
	logic [SREM_W-1:0]                srem_q;
	logic [hrss_pkg::ROOT_W-1:0]      root_q;
	hrss_pkg::result_t                res_q;
	logic                             out_valid_q;

	logic [SUM_W-1:0]                 job_sum;
	logic [CNT_W-1:0]                 job_cnt;
	logic                             job_ovf;
	logic [DSOR_W:0]                  rem_sh;
	logic                             div_ge;
	logic [DSOR_W-1:0]                rem_nx;
	logic [DEND_W-1:0]                quo_nx;
	logic                             div_done;
	logic [SREM_W+1:0]                srem_sh;
	logic [SREM_W+1:0]                trial;
	logic                             sq_ge;
	logic [hrss_pkg::ROOT_W-1:0]      root_cl;
	logic [hrss_pkg::PROD_W-1:0]      prod;
	logic [SPROD_W-1:0]               score_prod;
	logic [hrss_pkg::MEAN_W-1:0]      mean_nx;
	logic [hrss_pkg::SCORE_W-1:0]     score;

	assign {job_ovf, job_cnt, job_sum} = job_data;
	assign job_pop = (state_q == ST_IDLE) && job_valid;

	// Restoring divide, one quotient bit per cycle.
	assign rem_sh   = {rem_q, quo_q[DEND_W-1]};
	assign div_ge   = rem_sh >= {1'b0, dsor_q};
	assign rem_nx   = div_ge ? DSOR_W'(rem_sh - {1'b0, dsor_q}) : DSOR_W'(rem_sh);
	assign quo_nx   = {quo_q[DEND_W-2:0], div_ge};
	assign div_done = it_q == IT_W'(DEND_W - 1);
	assign mean_nx  = zero_cnt_q ? '0 : quo_nx[hrss_pkg::MEAN_W-1:0];

	// Square root, one result bit per cycle.
	assign srem_sh = {srem_q, rad_q[hrss_pkg::RAD_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sq_ge   = srem_sh >= trial;

	assign root_cl = (root_q > hrss_pkg::ROOT_MAX) ? hrss_pkg::ROOT_MAX : root_q;
	assign prod    = hrss_pkg::PROD_W'(hrss_pkg::ROOT_MAX - root_cl) *
		hrss_pkg::PROD_W'(hrss_pkg::SCORE_SCALE);

	// Scaled distance sits in quo_q after ST_MUL; divide by 255 through the reciprocal.
	assign score_prod = SPROD_W'(quo_q[hrss_pkg::PROD_W-1:0]) *
		SPROD_W'(hrss_pkg::DIV255_RECIP);
	assign score      = score_prod[hrss_pkg::DIV255_SHIFT +: hrss_pkg::SCORE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						it_q    <= '0;
						state_q <= ST_DIV_MEAN;
					end
				end
				ST_DIV_MEAN: begin
					if (div_done) begin
						it_q    <= '0;
						state_q <= ST_SQRT;
					end else begin
						it_q <= it_q + IT_W'(1);
					end
				end
				ST_SQRT: begin
					it_q <= it_q + IT_W'(1);
					if (it_q == IT_W'(hrss_pkg::ROOT_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					it_q    <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q      <= DEND_W'(job_sum);
				rem_q      <= '0;
				dsor_q     <= DSOR_W'(job_cnt);
				zero_cnt_q <= job_cnt == '0;
				ovf_q      <= job_ovf;
			end
			ST_DIV_MEAN: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (div_done) begin
					mean_q <= mean_nx;
					rad_q  <= {mean_nx, {(hrss_pkg::RAD_W - hrss_pkg::MEAN_W){1'b0}}};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				srem_q <= sq_ge ? SREM_W'(srem_sh - trial) : SREM_W'(srem_sh);
				root_q <= {root_q[hrss_pkg::ROOT_W-2:0], sq_ge};
				rad_q  <= {rad_q[hrss_pkg::RAD_W-3:0], 2'b00};
			end
			ST_MUL: begin
				quo_q <= DEND_W'(prod);
			end
			ST_OUT: begin
				if (!out_valid_q) begin
					res_q.score_q8      <= score;
					res_q.is_match      <= score >= threshold;
					res_q.mean_square   <= mean_q;
					res_q.too_many_bins <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign empty  = !out_valid_q;
	assign result = res_q;

endmodule

// ----- hdl/histogram_rms_similarity_score.sv -----
// RMS histogram distance similarity: top level tying front end, job queue and
// back end together. Depends on hrss_pkg, hrss_front, hrss_job_fifo, hrss_back.
//
// Usage:
//   Input queue: drive bin_a, bin_b and last with push; a request is taken on a
//   clock edge with push high and full low. One bin pair can be taken every
//   cycle while full is low. The pair with last high closes a histogram pair.
//   Result queue: one result per histogram pair, shown while empty is low and
//   removed on an edge with pop high. Pairs without last give no result.
//   Config: cfg_data is written to the match threshold when cfg_valid is high;
//   cfg_ready is always high. Write it only while the block is idle.
//   Flow: a closing request enters the job queue on the edge after it is
//   taken, and the back end picks it up once it is idle. The back end then
//   runs the DEND_W-bit mean divide one bit per cycle (DEND_W = max(sum width,
//   23), 24 at the default MAX_BINS), the square root, one step to scale by 100
//   and one to form and register the score. It takes one job at a time and
//   accepts a new job only after returning to idle. Histograms that close
//   faster than the back end finishes them stall the input through full
//   once the two-entry job queue fills.
//   Stall: while a result waits, the back end computes its next job and holds
//   it, and the queue fills; full then holds off every pair, not only closing ones.
//   Reset: clears sums, counts, queue and the result valid flag, threshold returns to 70.0.
module histogram_rms_similarity_score #(
	parameter int MAX_BINS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [hrss_pkg::BIN_W-1:0]      bin_a,
	input  logic [hrss_pkg::BIN_W-1:0]      bin_b,
	input  logic                            last,
	output logic                            empty,
	input  logic                            pop,
	output logic [hrss_pkg::SCORE_W-1:0]    score_q8,
	output logic                            is_match,
	output logic [hrss_pkg::MEAN_W-1:0]     mean_square,
	output logic                            too_many_bins,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hrss_pkg::SCORE_W-1:0]    cfg_data
);

	// Sum of squares needs room for MAX_BINS times 255 squared.
	localparam int SUM_W  = $clog2(MAX_BINS * 65025 + 1);
	localparam int CNT_W  = $clog2(MAX_BINS + 1);
	localparam int JOB_W  = SUM_W + CNT_W + 1;
	localparam int QDEPTH = 2;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	logic [hrss_pkg::SCORE_W-1:0] threshold_q;
	logic                         job_push;
	logic [JOB_W-1:0]             job_wdata;
	logic [JOB_W-1:0]             job_rdata;
	logic                         job_valid;
	logic                         job_pop;
	logic [QCNT_W-1:0]            q_count;
	hrss_pkg::result_t            result;

	// Threshold register: always ready, update on a valid request.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= hrss_pkg::THRESH_RESET;
		end else if (cfg_valid) begin
			threshold_q <= cfg_data;
		end
	end

	// Front end: square, accumulate, close a pair into a job record.
	hrss_front #(
		.MAX_BINS (MAX_BINS),
		.SUM_W    (SUM_W),
		.CNT_W    (CNT_W),
		.QDEPTH   (QDEPTH),
		.QCNT_W   (QCNT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.bin_a    (bin_a),
		.bin_b    (bin_b),
		.last     (last),
		.q_count  (q_count),
		.job_push (job_push),
		.job_data (job_wdata)
	);

	// Job queue decouples accumulation from the long divide and root.
	hrss_job_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QDEPTH),
		.CNT_W (QCNT_W)
	) u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_push),
		.wr_data   (job_wdata),
		.rd_en     (job_pop),
		.rd_data   (job_rdata),
		.not_empty (job_valid),
		.count     (q_count)
	);

	// Back end: mean, root, score, and the output register.
	hrss_back #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_rdata),
		.job_pop   (job_pop),
		.threshold (threshold_q),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	assign score_q8      = result.score_q8;
	assign is_match      = result.is_match;
	assign mean_square   = result.mean_square;
	assign too_many_bins = result.too_many_bins;

endmodule
